FILE: rtl/tfpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfpf_pkg: shared types and constants of the thermal frame packet framer
// Frame geometry, header constants, action codes and the byte job record.
// ----------------------------------------------------------------------------
package tfpf_pkg;

  // Frame geometry
  localparam int PIXEL_ROWS     = 24;
  localparam int WORDS_PER_ROW  = 32;
  localparam int AUX_WORD_COUNT = 64;

  localparam int PIXEL_TOTAL = PIXEL_ROWS * WORDS_PER_ROW;
  localparam int FRAME_TOTAL = PIXEL_TOTAL + AUX_WORD_COUNT;

  // Words sent in raw mode for each subpage (eeprom mode sends FRAME_TOTAL)
  localparam int RAW_WORDS_SUB0 = ((PIXEL_ROWS + 1) / 2) * WORDS_PER_ROW + AUX_WORD_COUNT;
  localparam int RAW_WORDS_SUB1 = (PIXEL_ROWS / 2) * WORDS_PER_ROW + AUX_WORD_COUNT;

  localparam int WCNT_W = $clog2(FRAME_TOTAL + 1);
  localparam int COL_W  = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;

  // Byte position within one job
  localparam int IDX_W        = 5;
  localparam int HDR_LAST_IDX = 27;

  // Header constants
  localparam logic [7:0] MAGIC_M      = 8'h4D;
  localparam logic [7:0] MAGIC_L      = 8'h4C;
  localparam logic [7:0] MAGIC_X      = 8'h58;
  localparam logic [7:0] MAGIC_RAW    = 8'h52;
  localparam logic [7:0] MAGIC_EEPROM = 8'h45;
  localparam logic [7:0] HDR_VERSION  = 8'h01;
  localparam logic [7:0] FLAG_SUBPAGE = 8'h01;
  localparam logic [7:0] FLAG_COMPACT = 8'h40;
  localparam logic [7:0] FLAG_OVERRUN = 8'h80;
  localparam int         STATUS_OVERRUN_BIT = 3;

  // Data job byte positions
  localparam logic [IDX_W-1:0] DATA_HI_IDX  = IDX_W'(0);
  localparam logic [IDX_W-1:0] DATA_LO_IDX  = IDX_W'(1);
  localparam logic [IDX_W-1:0] SUM_LO_IDX   = IDX_W'(2);
  localparam logic [IDX_W-1:0] SUM_HI_IDX   = IDX_W'(3);

  typedef enum logic [1:0] {
    ACT_START_RAW    = 2'd0,
    ACT_START_EEPROM = 2'd1,
    ACT_DATA_WORD    = 2'd2,
    ACT_RESET_SEQ    = 2'd3
  } action_t;

  // One pending run of output bytes: a header or a data/checksum group
  typedef struct packed {
    logic        hdr;
    logic        ee;
    logic [7:0]  flags;
    logic [15:0] words;
    logic [31:0] seq;
    logic [31:0] tick;
    logic [31:0] rtime;
    logic [15:0] status;
    logic [15:0] control;
    logic [15:0] word;
  } job_t;

endpackage
`default_nettype wire

FILE: rtl/tfpf_byte_mux.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfpf_byte_mux: byte selector of the packet framer
// Picks the packet byte at a given position of the current job.
// ----------------------------------------------------------------------------
module tfpf_byte_mux
  import tfpf_pkg::*;
(
  input  job_t             job,
  input  logic [IDX_W-1:0] idx,
  input  logic [15:0]      sum,
  output logic [7:0]       out_byte
);

  logic [31:0] size;

  // Payload size is twice the word count
  assign size = {15'd0, job.words, 1'b0};

  // Select the byte of a header or of a data/checksum group
  always_comb begin
    out_byte = 8'd0;
    if (job.hdr) begin
      case (idx)
        5'd0:  out_byte = MAGIC_M;
        5'd1:  out_byte = MAGIC_L;
        5'd2:  out_byte = MAGIC_X;
        5'd3:  out_byte = job.ee ? MAGIC_EEPROM : MAGIC_RAW;
        5'd4:  out_byte = HDR_VERSION;
        5'd5:  out_byte = job.flags;
        5'd6:  out_byte = job.words[7:0];
        5'd7:  out_byte = job.words[15:8];
        5'd8:  out_byte = job.seq[7:0];
        5'd9:  out_byte = job.seq[15:8];
        5'd10: out_byte = job.seq[23:16];
        5'd11: out_byte = job.seq[31:24];
        5'd12: out_byte = job.tick[7:0];
        5'd13: out_byte = job.tick[15:8];
        5'd14: out_byte = job.tick[23:16];
        5'd15: out_byte = job.tick[31:24];
        5'd16: out_byte = job.rtime[7:0];
        5'd17: out_byte = job.rtime[15:8];
        5'd18: out_byte = job.rtime[23:16];
        5'd19: out_byte = job.rtime[31:24];
        5'd20: out_byte = job.status[7:0];
        5'd21: out_byte = job.status[15:8];
        5'd22: out_byte = job.control[7:0];
        5'd23: out_byte = job.control[15:8];
        5'd24: out_byte = size[7:0];
        5'd25: out_byte = size[15:8];
        5'd26: out_byte = size[23:16];
        5'd27: out_byte = size[31:24];
        default: out_byte = 8'd0;
      endcase
    end else begin
      case (idx)
        DATA_HI_IDX: out_byte = job.word[15:8];
        DATA_LO_IDX: out_byte = job.word[7:0];
        SUM_LO_IDX:  out_byte = sum[7:0];
        SUM_HI_IDX:  out_byte = sum[15:8];
        default:     out_byte = 8'd0;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/thermal_frame_packet_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thermal_frame_packet_framer: sensor word to packet byte stream framer
// Builds headers, selects frame words and appends the packet checksum.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one action per transaction: s_tuser holds the
//   action code, s_tdata the status, control, tick, read time and word.
//   The master channel returns one packet byte per transaction, with m_tlast
//   high on the final checksum byte of a packet.
//   A start transaction yields a 28-byte header, a data word yields up to two
//   payload bytes plus two checksum bytes on the last frame word.
//   The first byte of a transaction is valid in the cycle after it is
//   accepted. Throughput: one byte per cycle while m_tready is high. The
//   job register feeding the byte selector sets the rate: the next
//   transaction is accepted in the cycle the last byte of the current job
//   is taken.
//   Reset clears the sequence counter, the checksum and all packet state;
//   no packet is open afterwards. When the receiver stalls, the current byte
//   holds and s_tready drops once the pending job cannot retire.
// ----------------------------------------------------------------------------
module thermal_frame_packet_framer
  import tfpf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [15:0] sensor_status, [31:16] sensor_control, [63:32] tick_ms,
  // [95:64] read_time_us, [111:96] frame_word
  input  wire logic [111:0] s_tdata,
  // [1:0] action
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [7:0] out_byte
  output logic [7:0]        m_tdata,
  output logic              m_tlast
);

  // Input fields
  action_t     action;
  logic [15:0] sensor_status;
  logic [15:0] sensor_control;
  logic [31:0] tick_ms;
  logic [31:0] read_time_us;
  logic [15:0] frame_word;

  // Packet state
  logic [31:0]       sequence_count;
  logic [15:0]       running_sum;
  logic [WCNT_W-1:0] word_counter;
  logic [COL_W-1:0]  col_count;
  logic              row_odd;
  logic              eeprom_mode;
  logic              subpage_bit;
  logic              packet_open;

  // Job (result) register
  job_t              job;
  job_t              job_next;
  logic              busy;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  idx_first;
  logic [IDX_W-1:0]  last_next;

  logic in_fire;
  logic out_fire;
  logic job_done;
  logic load;
  logic is_start;
  logic is_data;
  logic send;
  logic close;
  logic in_pixels;
  logic sub_in;
  logic [7:0] out_byte;

  assign action         = action_t'(s_tuser);
  assign sensor_status  = s_tdata[15:0];
  assign sensor_control = s_tdata[31:16];
  assign tick_ms        = s_tdata[63:32];
  assign read_time_us   = s_tdata[95:64];
  assign frame_word     = s_tdata[111:96];

  // Handshakes
  assign out_fire = busy && m_tready;
  assign job_done = out_fire && (idx == last_idx);
  assign s_tready = !busy || job_done;
  assign in_fire  = s_tvalid && s_tready;

  // Decode the action and the word selection
  assign sub_in    = sensor_status[0];
  assign in_pixels = word_counter < WCNT_W'(PIXEL_TOTAL);

  always_comb begin
    is_start = 1'b0;
    is_data  = 1'b0;
    unique case (action) inside
      ACT_START_RAW, ACT_START_EEPROM: is_start = 1'b1;
      ACT_DATA_WORD:                   is_data  = packet_open;
      ACT_RESET_SEQ:                   is_start = 1'b0;
      default:                         is_start = 1'b0;
    endcase
  end

  assign send  = eeprom_mode || !in_pixels || (row_odd == subpage_bit);
  assign close = word_counter == WCNT_W'(FRAME_TOTAL - 1);
  assign load  = in_fire && (is_start || (is_data && (send || close)));

  // Build the next job from the accepted transaction
  always_comb begin
    job_next      = '0;
    job_next.word = frame_word;
    job_next.tick = tick_ms;
    idx_first     = DATA_HI_IDX;
    last_next     = DATA_LO_IDX;
    if (is_start) begin
      job_next.hdr = 1'b1;
      idx_first    = IDX_W'(0);
      last_next    = IDX_W'(HDR_LAST_IDX);
      if (action == ACT_START_EEPROM) begin
        job_next.ee    = 1'b1;
        job_next.words = 16'(FRAME_TOTAL);
      end else begin
        job_next.flags   = FLAG_COMPACT | (sub_in ? FLAG_SUBPAGE : 8'd0)
                         | (sensor_status[STATUS_OVERRUN_BIT] ? FLAG_OVERRUN : 8'd0);
        job_next.words   = sub_in ? 16'(RAW_WORDS_SUB1) : 16'(RAW_WORDS_SUB0);
        job_next.seq     = sequence_count;
        job_next.rtime   = read_time_us;
        job_next.status  = sensor_status;
        job_next.control = sensor_control;
      end
    end else begin
      idx_first = send ? DATA_HI_IDX : SUM_LO_IDX;
      last_next = close ? SUM_HI_IDX : DATA_LO_IDX;
    end
  end

  // Control state: packet tracking and sequence counter
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_count <= '0;
      word_counter   <= '0;
      col_count      <= '0;
      row_odd        <= 1'b0;
      eeprom_mode    <= 1'b0;
      subpage_bit    <= 1'b0;
      packet_open    <= 1'b0;
    end else if (in_fire) begin
      if (is_start) begin
        word_counter <= '0;
        col_count    <= '0;
        row_odd      <= 1'b0;
        packet_open  <= 1'b1;
        eeprom_mode  <= (action == ACT_START_EEPROM);
        subpage_bit  <= (action == ACT_START_RAW) && sub_in;
        if (action == ACT_START_RAW) begin
          sequence_count <= sequence_count + 32'd1;
        end
      end else if (action == ACT_RESET_SEQ) begin
        sequence_count <= '0;
      end else if (is_data) begin
        word_counter <= word_counter + WCNT_W'(1);
        if (col_count == COL_W'(WORDS_PER_ROW - 1)) begin
          col_count <= '0;
          row_odd   <= !row_odd;
        end else begin
          col_count <= col_count + COL_W'(1);
        end
        if (close) begin
          packet_open <= 1'b0;
        end
      end
    end
  end

  // Job register and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= '0;
      last_idx <= '0;
    end else begin
      if (job_done) begin
        busy <= 1'b0;
      end else if (out_fire) begin
        idx <= idx + IDX_W'(1);
      end
      if (load) begin
        busy     <= 1'b1;
        idx      <= idx_first;
        last_idx <= last_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_next;
    end
  end

  // Accumulate the checksum over header and payload bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (load && is_start) begin
      running_sum <= '0;
    end else if (out_fire && (job.hdr || idx < SUM_LO_IDX)) begin
      running_sum <= running_sum + {8'd0, out_byte};
    end
  end

  tfpf_byte_mux u_byte_mux (
    .job      (job),
    .idx      (idx),
    .sum      (running_sum),
    .out_byte (out_byte)
  );

  assign m_tvalid = busy;
  assign m_tdata  = out_byte;
  assign m_tlast  = !job.hdr && (idx == SUM_HI_IDX);

endmodule
`default_nettype wire
